// File: rtl/core/cse_pkg.sv
// Shared types, codes and character helpers for the C string escaper.
package cse_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_OCT  = 2'd1;
    localparam logic [1:0] PRE_HEX  = 2'd2;

    localparam logic [1:0] MAIN_NONE  = 2'd0;
    localparam logic [1:0] MAIN_PLAIN = 2'd1;
    localparam logic [1:0] MAIN_SHORT = 2'd2;

    localparam logic [1:0] CLASS_PLAIN   = 2'd0;
    localparam logic [1:0] CLASS_SHORT   = 2'd1;
    localparam logic [1:0] CLASS_NUMERIC = 2'd2;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    typedef struct packed {
        logic [1:0] pre_kind;
        logic [7:0] pre_byte;
        logic [1:0] main_kind;
        logic [7:0] main_char;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? 8'h41 : 8'h61;
        if (d < 4'd10)
            hex_char = CHAR_ZERO + {4'd0, d};
        else
            hex_char = base + {4'd0, d} - 8'd10;
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] c);
        is_hex_digit = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                       (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [1:0] byte_class(input logic [7:0] v);
        if (v == 8'h22 || v == 8'h27 || v == 8'h5C)
            byte_class = CLASS_SHORT;
        else if (v >= 8'd7 && v <= 8'd13)
            byte_class = CLASS_SHORT;
        else if (v < 8'd32 || v >= 8'd128)
            byte_class = CLASS_NUMERIC;
        else
            byte_class = CLASS_PLAIN;
    endfunction

    function automatic logic [7:0] short_letter(input logic [7:0] v);
        case (v)
            8'd7:    short_letter = 8'h61;
            8'd8:    short_letter = 8'h62;
            8'd9:    short_letter = 8'h74;
            8'd10:   short_letter = 8'h6E;
            8'd11:   short_letter = 8'h76;
            8'd12:   short_letter = 8'h66;
            8'd13:   short_letter = 8'h72;
            default: short_letter = v;
        endcase
    endfunction

endpackage

// File: rtl/core/cse_front.sv
// Front end: classifies input transactions, holds the deferred byte, builds commands.
module cse_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               op,
    input  logic [7:0]         in_byte,
    output logic               cmd_valid,
    output cse_pkg::cmd_t      cmd
);

    logic       pending_valid_reg;
    logic       pending_valid_next;
    logic [7:0] pending_byte_reg;
    logic [7:0] pending_byte_next;
    logic [1:0] cls;

    always_comb
    begin
        cls                = cse_pkg::byte_class(in_byte);
        pending_valid_next = pending_valid_reg;
        pending_byte_next  = pending_byte_reg;
        cmd.pre_kind       = cse_pkg::PRE_NONE;
        cmd.pre_byte       = pending_byte_reg;
        cmd.main_kind      = cse_pkg::MAIN_NONE;
        cmd.main_char      = in_byte;
        if (op)
        begin
            if (pending_valid_reg)
                cmd.pre_kind = cse_pkg::PRE_HEX;
            pending_valid_next = 1'b0;
            pending_byte_next  = 8'd0;
        end
        else
        begin
            if (pending_valid_reg)
                cmd.pre_kind = cse_pkg::is_hex_digit(in_byte) ? cse_pkg::PRE_OCT
                                                              : cse_pkg::PRE_HEX;
            pending_valid_next = 1'b0;
            pending_byte_next  = 8'd0;
            unique case (cls)
                cse_pkg::CLASS_PLAIN:
                begin
                    cmd.main_kind = cse_pkg::MAIN_PLAIN;
                end
                cse_pkg::CLASS_SHORT:
                begin
                    cmd.main_kind = cse_pkg::MAIN_SHORT;
                    cmd.main_char = cse_pkg::short_letter(in_byte);
                end
                default:
                begin
                    pending_valid_next = 1'b1;
                    pending_byte_next  = in_byte;
                end
            endcase
        end
        cmd_valid = accept && (cmd.pre_kind != cse_pkg::PRE_NONE ||
                               cmd.main_kind != cse_pkg::MAIN_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_byte_reg  <= 8'd0;
        end
        else if (accept)
        begin
            pending_valid_reg <= pending_valid_next;
            pending_byte_reg  <= pending_byte_next;
        end
    end

endmodule

// File: rtl/core/cse_queue.sv
// Command queue between front and back ends.
module cse_queue
#(
    parameter int DEPTH = cse_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cse_pkg::cmd_t  wdata,
    output logic           full,
    input  logic           pop,
    output cse_pkg::cmd_t  rdata,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cse_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/core/cse_back.sv
// Back end: expands commands into escaped chars, one per cycle while the output reg is free.
module cse_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           hex_upper,
    input  cse_pkg::cmd_t  q_data,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_char,
    output logic           out_last
);

    cse_pkg::cmd_t cur_reg;
    logic          cur_valid_reg;
    logic [2:0]    step_reg;
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;

    logic [2:0]    pre_len;
    logic [2:0]    main_len;
    logic [2:0]    total;
    logic [2:0]    main_idx;
    logic          is_last;
    logic [7:0]    ch;
    logic          out_free;
    logic          advance;
    logic          take;

    always_comb
    begin
        pre_len = (cur_reg.pre_kind != cse_pkg::PRE_NONE) ? 3'd4 : 3'd0;
        case (cur_reg.main_kind)
            cse_pkg::MAIN_PLAIN: main_len = 3'd1;
            cse_pkg::MAIN_SHORT: main_len = 3'd2;
            default:             main_len = 3'd0;
        endcase
        total    = pre_len + main_len;
        is_last  = step_reg == total - 3'd1;
        main_idx = step_reg - pre_len;
        ch       = cse_pkg::CHAR_BSLASH;
        if (step_reg < pre_len)
        begin
            case (step_reg[1:0])
                2'd0: ch = cse_pkg::CHAR_BSLASH;
                2'd1: ch = (cur_reg.pre_kind == cse_pkg::PRE_OCT)
                         ? cse_pkg::CHAR_ZERO + {6'd0, cur_reg.pre_byte[7:6]}
                         : cse_pkg::CHAR_X;
                2'd2: ch = (cur_reg.pre_kind == cse_pkg::PRE_OCT)
                         ? cse_pkg::CHAR_ZERO + {5'd0, cur_reg.pre_byte[5:3]}
                         : cse_pkg::hex_char(cur_reg.pre_byte[7:4], hex_upper);
                default: ch = (cur_reg.pre_kind == cse_pkg::PRE_OCT)
                         ? cse_pkg::CHAR_ZERO + {5'd0, cur_reg.pre_byte[2:0]}
                         : cse_pkg::hex_char(cur_reg.pre_byte[3:0], hex_upper);
            endcase
        end
        else if (cur_reg.main_kind == cse_pkg::MAIN_PLAIN || main_idx[0])
            ch = cur_reg.main_char;
        out_free = !out_valid_reg || pop;
        advance  = cur_valid_reg && out_free;
        take     = !cur_valid_reg || (advance && is_last);
        q_pop    = take && !q_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
        end
        else if (take)
        begin
            cur_valid_reg <= !q_empty;
            step_reg      <= 3'd0;
        end
        else if (advance)
            step_reg <= step_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= q_data;
        if (advance)
        begin
            out_char_reg <= ch;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    assign empty    = !out_valid_reg;
    assign out_char = out_char_reg;
    assign out_last = out_last_reg;

endmodule

// File: rtl/core/c_string_escaper_core.sv
// Top level of the C string escaper: byte stream in, C string literal text out.
//
// Input side is a queue push port: a transaction (op, in_byte) is taken when push is
// high and full is low. op = 0 carries a data byte, op = 1 flushes a deferred byte.
// Output side is a queue read port: while empty is low, out_char/out_last show the
// oldest character; pop takes it. out_last marks the final character of an input
// transaction. Transactions that yield no text produce nothing on the output.
// hex_uppercase is written through cfg_we/cfg_data only while the block is idle; the user
// must keep to this, the block does not enforce it. Commands pass through the queue and
// the back end's command register. Throughput: one output character per cycle while pop
// drains the single-character output register; a transaction yields up to six characters,
// so input runs at one per cycle for plain text and slows to the output rate on escape
// sequences. The command queue (QUEUE_DEPTH entries) absorbs the difference; full rises
// when it fills. When pop stays low the output holds and the queue backs up to full.
// Reset clears the deferred byte, the queue and the output, and sets upper-case hex.
module c_string_escaper_core
#(
    parameter int QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       out_last,
    input  logic       cfg_we,
    input  logic       cfg_data
);

    logic          hex_upper_reg;
    logic          accept;
    logic          cmd_valid;
    cse_pkg::cmd_t cmd;
    cse_pkg::cmd_t q_data;
    logic          q_empty;
    logic          q_pop;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hex_upper_reg <= 1'b1;
        else if (cfg_we)
            hex_upper_reg <= cfg_data;
    end

    cse_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .in_byte   (in_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    cse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_valid),
        .wdata (cmd),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_data),
        .empty (q_empty)
    );

    cse_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hex_upper (hex_upper_reg),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_char  (out_char),
        .out_last  (out_last)
    );

endmodule
